/* rtl/aads_pkg.sv */
package aads_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned RootW  = DataW / 2;
	localparam int unsigned RemW   = RootW * 2 + 2;
	localparam int unsigned CntW   = 6;

	// operation codes carried in req_type
	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_MOD  = 3'd5,
		OP_SQRT = 3'd6
	} op_t;

	// status codes returned with each result word
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_DIVZERO = 2'd1,
		STAT_NEGROOT = 2'd2,
		STAT_DIVOVF  = 2'd3
	} status_t;

	// control from the sequencer to the iterative unit
	typedef struct packed {
		logic start;
		logic is_sqrt;
	} aads_ctl_t;

	// status from the iterative unit back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} aads_stat_t;

endpackage

/* rtl/aads_if.sv */
interface aads_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic signed [31:0] operand;

	modport source (output valid, req_type, operand, input ready);
	modport sink   (input valid, req_type, operand, output ready);
endinterface

interface aads_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	logic [1:0]         status;

	modport source (output valid, result, status, input ready);
	modport sink   (input valid, result, status, output ready);
endinterface

/* rtl/aads_iter.sv */
// Radix-2 restoring divider / digit-by-digit square root sharing one subtractor.
module aads_iter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  aads_pkg::aads_ctl_t           ctl,
	input  logic [aads_pkg::DataW-1:0]    num,
	input  logic [aads_pkg::DataW-1:0]    den,
	output aads_pkg::aads_stat_t          stat,
	output logic [aads_pkg::DataW-1:0]    quo,
	output logic [aads_pkg::DataW-1:0]    rem
);
	import aads_pkg::*;

	logic [DataW-1:0] work_q;   // dividend/radicand bits out, quotient bits in
	logic [RemW-1:0]  rem_q;
	logic [RootW-1:0] root_q;
	logic [DataW-1:0] den_q;
	logic [CntW-1:0]  cnt_q;
	logic             sqrt_q;
	logic             busy_q;
	logic             done_q;

	logic [RemW-1:0]  sub_a;
	logic [RemW-1:0]  sub_b;
	logic [RemW:0]    diff;
	logic             fits;

	// shared trial subtract
	always_comb begin
		if (sqrt_q) begin
			sub_a = {rem_q[RemW-3:0], work_q[DataW-1 -: 2]};
			sub_b = {{(RemW-RootW-2){1'b0}}, root_q, 2'b01};
		end else begin
			sub_a = {rem_q[RemW-2:0], work_q[DataW-1]};
			sub_b = {{(RemW-DataW){1'b0}}, den_q};
		end
		diff = {1'b0, sub_a} - {1'b0, sub_b};
		fits = ~diff[RemW];
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sqrt_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				sqrt_q <= ctl.is_sqrt;
				cnt_q  <= ctl.is_sqrt ? CntW'(RootW - 1) : CntW'(DataW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			work_q <= num;
			den_q  <= den;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[RemW-1:0] : sub_a;
			if (sqrt_q) begin
				work_q <= {work_q[DataW-3:0], 2'b00};
				root_q <= {root_q[RootW-2:0], fits};
			end else begin
				work_q <= {work_q[DataW-2:0], fits};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo = sqrt_q ? {{(DataW-RootW){1'b0}}, root_q} : work_q;
	assign rem = rem_q[DataW-1:0];

endmodule

/* rtl/accumulator_alu_div_sqrt.sv */
// Accumulator calculator with a 32-bit signed accumulator.
// Channels: req (sink) takes one word of req_type and operand; rsp (source)
// returns one word per request: the new accumulator value and a status.
// Both use valid/ready; a word moves when both are high at a clock edge.
// The block handles one request at a time; req.ready is high only while
// it is idle and no result is waiting.
// Load, add, sub, mul, an unused code or any flagged case raise rsp.valid in
// the cycle after the request is accepted; square root first runs 16 two-bit
// steps, div and mod 32 one-bit steps, of the shared subtractor.
// The result is held on rsp until taken; the block is ready again in the
// cycle after the handshake.
// Divide by zero, most-negative / -1 and root of a negative value set a
// status code and leave the accumulator unchanged.
// Add, sub and mul wrap modulo 2^32.
// Reset clears the accumulator to zero and drops rsp.valid.
// A stalled receiver holds the block: no new request is taken until the
// pending result is accepted.
module accumulator_alu_div_sqrt (
	input  logic         clk,
	input  logic         arst_n,
	aads_req_if.sink     req,
	aads_rsp_if.source   rsp
);
	import aads_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_OUT
	} state_t;

	state_t           state_q;
	logic [DataW-1:0] acc_q;
	status_t          status_q;
	op_t              op_q;
	logic             neg_q_q;
	logic             neg_r_q;

	logic             req_acc;
	op_t              op;
	logic [DataW-1:0] opnd;
	logic [DataW-1:0] mag_a;
	logic [DataW-1:0] mag_b;
	logic [DataW-1:0] prod;
	logic             div_zero;
	logic             div_ovf;
	aads_ctl_t        ctl;
	aads_stat_t       ustat;
	logic [DataW-1:0] unum;
	logic [DataW-1:0] uden;
	logic [DataW-1:0] uquo;
	logic [DataW-1:0] urem;

	assign req_acc   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.result = acc_q;
	assign rsp.status = status_q;

	// decode and operand conditioning
	always_comb begin
		op       = op_t'(req.req_type);
		opnd     = req.operand;
		mag_a    = acc_q[DataW-1] ? (DataW'(0) - acc_q) : acc_q;
		mag_b    = opnd[DataW-1] ? (DataW'(0) - opnd) : opnd;
		prod     = DataW'(acc_q * opnd);
		div_zero = (opnd == '0);
		div_ovf  = (acc_q == {1'b1, {(DataW-1){1'b0}}}) && (opnd == '1);
		ctl.start   = 1'b0;
		ctl.is_sqrt = (op == OP_SQRT);
		unum     = mag_a;
		uden     = mag_b;
		if (op == OP_SQRT) begin
			unum = opnd;
			uden = '0;
		end
		if (req_acc) begin
			case (op)
				OP_DIV, OP_MOD: ctl.start = !div_zero && !div_ovf;
				OP_SQRT:        ctl.start = !opnd[DataW-1];
				default:        ctl.start = 1'b0;
			endcase
		end
	end

	aads_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.num    (unum),
		.den    (uden),
		.stat   (ustat),
		.quo    (uquo),
		.rem    (urem)
	);

	// request sequencer, accumulator and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			acc_q    <= '0;
			status_q <= STAT_OK;
			op_q     <= OP_LOAD;
			neg_q_q  <= 1'b0;
			neg_r_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						status_q <= STAT_OK;
						op_q     <= op;
						neg_q_q  <= acc_q[DataW-1] ^ opnd[DataW-1];
						neg_r_q  <= acc_q[DataW-1];
						state_q  <= ST_OUT;
						case (op)
							OP_LOAD: acc_q <= opnd;
							OP_ADD:  acc_q <= acc_q + opnd;
							OP_SUB:  acc_q <= acc_q - opnd;
							OP_MUL:  acc_q <= prod;
							OP_DIV, OP_MOD: begin
								if (div_zero) begin
									status_q <= STAT_DIVZERO;
								end else if (div_ovf) begin
									status_q <= STAT_DIVOVF;
								end else begin
									state_q <= ST_RUN;
								end
							end
							OP_SQRT: begin
								if (opnd[DataW-1]) begin
									status_q <= STAT_NEGROOT;
								end else begin
									state_q <= ST_RUN;
								end
							end
							default: acc_q <= acc_q;
						endcase
					end
				end
				ST_RUN: begin
					if (ustat.done) begin
						state_q <= ST_OUT;
						case (op_q)
							OP_DIV:  acc_q <= neg_q_q ? (DataW'(0) - uquo) : uquo;
							OP_MOD:  acc_q <= neg_r_q ? (DataW'(0) - urem) : urem;
							default: acc_q <= uquo;
						endcase
					end
				end
				ST_OUT: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/aads_checker.sv */
module aads_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [2:0]  req_type,
	input logic [31:0] req_operand,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_result,
	input logic [1:0]  rsp_status
);
	import aads_pkg::*;

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// a pending result word stays up and unchanged until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_status))
		else $error("rsp word dropped or changed while stalled");

	// never ready for a request while a result is waiting
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request taken while result pending");

	// an accepted request blocks the next one
	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("ready right after accepting a request");

	// a load returns its operand in the next cycle with good status
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_type == OP_LOAD) |=>
			rsp_valid && (rsp_result == $past(req_operand)) && (rsp_status == STAT_OK))
		else $error("load result wrong");

endmodule

bind accumulator_alu_div_sqrt aads_checker u_aads_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_type    (req.req_type),
	.req_operand (req.operand),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_result  (rsp.result),
	.rsp_status  (rsp.status)
);
